// File: design/rc4_variable_size_keystream_assert.svh
// Assertion macros for the RC4 keystream block.
// Used by the port checker; no other dependencies.
`ifndef RC4_VARIABLE_SIZE_KEYSTREAM_ASSERT_SVH
`define RC4_VARIABLE_SIZE_KEYSTREAM_ASSERT_SVH
`define RC4_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RC4_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) prop) else $error("reset check failed");
`endif

// File: design/rc4_pkg.sv
// Package for the RC4 keystream block: types and constants.
// No dependencies.
`timescale 1ns / 1ps
package rc4_pkg;
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;
    localparam logic [1:0] REG_ENTRIES = 2'd0;
    localparam logic [1:0] REG_KEYLEN  = 2'd1;
    localparam logic [1:0] REG_ROUNDS  = 2'd2;
    localparam logic [1:0] REG_STEPS   = 2'd3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef struct packed {
        logic       kind;
        logic [7:0] key_index;
        logic [7:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] keystream_byte;
        logic       key_missing;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic init_start;   // load table identity and counters
        logic ksa_start;
        logic gen_start;
        logic sched_done;   // clear gen indices
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic init_done;
        logic ksa_done;
        logic gen_done;
    } dp_status_t;
endpackage

// File: design/rc4_if.sv
// Valid/ready channel interface for the RC4 keystream block.
// Payload type is a parameter.
`timescale 1ns / 1ps
interface rc4_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/rc4_variable_size_keystream.sv
// RC4 keystream generator with a variable-size permutation (N from 2 to 256).
// Input channel in: kind 0 loads key_value at key_index, kind 1 requests a byte.
// Output channel out: one result (keystream_byte, key_missing) per request.
// Configuration: cfg_we/cfg_index/cfg_data, registers 0..3 = state_entries,
// key_length, schedule_rounds, steps_per_output; out-of-range values clamp.
// A key load is written into the key RAM at the edge of its transfer. A request without
// key has its result registered at the edge of its transfer. Every index sum is reduced
// mod N by compare and subtract in the issuing state, P_M1 and P_M2.
// The first request after a key load first runs the schedule: the identity is set, each
// schedule round steps through P_K0, P_K1, P_M1, P_M2, P_K2, P_K3 and P_K4, and the
// controller hands over in S_KST and S_OUT. Each generation step runs three reductions,
// two reads, two swap writes and one output read, using a permutation RAM with one write
// and one read port; a request runs steps_per_output steps before its result is registered.
// One item is in work at a time; input is held off until its result is
// registered, and while that result waits for the receiver no new item enters.
// Reset clears the generation indices, key-present and scrambled flags; the RAMs are not
// cleared. A stalled receiver holds the result stable.
`timescale 1ns / 1ps
module rc4_variable_size_keystream #(
    parameter int MAX_ENTRIES   = 256,
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rc4_if.sink                            in_ch,
    rc4_if.source                          out_ch,
    input  logic                           cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rc4_pkg::*;
    logic [8:0]  ent_reg, len_reg, stp_reg;
    logic [16:0] rnd_reg;
    logic [8:0]  n_val, len_val, steps_val;
    logic [16:0] rounds_val;
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [7:0]  last_byte;
    logic        key_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= 9'd256; len_reg <= 9'd16; rnd_reg <= 17'd256; stp_reg <= 9'd1;
        end
        else if (cfg_we && cfg_index[2] == 1'b0)
        begin
            case (cfg_index[1:0])
                REG_ENTRIES: ent_reg <= cfg_data[8:0];
                REG_KEYLEN:  len_reg <= cfg_data[8:0];
                REG_ROUNDS:  rnd_reg <= cfg_data;
                default:     stp_reg <= cfg_data[8:0];
            endcase
        end
    end

    always_comb
    begin
        n_val = (ent_reg < 9'd2) ? 9'd2 :
            ((ent_reg > 9'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES) : ent_reg);
        len_val = (len_reg < 9'd1) ? 9'd1 :
            ((len_reg > 9'(MAX_KEY_BYTES)) ? 9'(MAX_KEY_BYTES) : len_reg);
        rounds_val = (rnd_reg == '0) ? 17'd1 : ((rnd_reg > 17'd65536) ? 17'd65536 : rnd_reg);
        steps_val = (stp_reg == '0) ? 9'd1 : ((stp_reg > 9'd256) ? 9'd256 : stp_reg);
    end

    rc4_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .last_byte(last_byte), .status(status), .cmd(cmd), .key_we(key_we)
    );

    rc4_dp #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .key_we(key_we),
        .key_waddr(in_ch.data.key_index), .key_wdata(in_ch.data.key_value),
        .n_val(n_val), .len_val(len_val), .rounds_val(rounds_val),
        .steps_val(steps_val), .cmd(cmd), .status(status), .last_byte(last_byte)
    );
endmodule

// File: design/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/rc4_dp.sv
// Datapath of the RC4 block: permutation RAM, key RAM, indices and
// step sequencing. Depends on rc4_pkg and rc4_ram.
`timescale 1ns / 1ps
module rc4_dp #(
    parameter int MAX_ENTRIES   = 256,
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_we,
    input  logic [7:0]        key_waddr,
    input  logic [7:0]        key_wdata,
    input  logic [8:0]        n_val,
    input  logic [8:0]        len_val,
    input  logic [16:0]       rounds_val,
    input  logic [8:0]        steps_val,
    input  rc4_pkg::dp_cmd_t  cmd,
    output rc4_pkg::dp_status_t status,
    output logic [7:0]        last_byte
);
    import rc4_pkg::*;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    localparam logic [4:0] P_IDLE = 5'd0, P_INIT = 5'd1, P_K0 = 5'd2, P_K1 = 5'd3,
        P_K2 = 5'd4, P_K3 = 5'd5, P_K4 = 5'd6, P_G0 = 5'd7, P_G1 = 5'd8, P_G2 = 5'd9,
        P_G3 = 5'd10, P_G4 = 5'd11, P_G5 = 5'd12, P_G6 = 5'd13, P_G7 = 5'd14,
        P_M1 = 5'd15, P_M2 = 5'd16;

    logic [4:0]  ph_reg, ph_next;
    logic [4:0]  ret_reg, ret_next;
    logic [8:0]  a_reg, a_next;     // table index i / a
    logic [8:0]  b_reg, b_next;     // key index
    logic [8:0]  j_reg, j_next;
    logic [16:0] cnt_reg, cnt_next;
    logic [7:0]  si_reg, si_next;
    logic [7:0]  gi_reg, gi_next, gj_reg, gj_next;
    logic [7:0]  last_reg, last_next;
    logic [9:0]  rem_reg, rem_next;

    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [7:0]    s_wdata, s_rdata, k_rdata;
    logic [KW-1:0] k_raddr;
    logic [8:0]    a_inc, b_inc;

    rc4_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_perm (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );
    rc4_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key (
        .clk(clk), .we(key_we), .waddr(key_waddr[KW-1:0]), .wdata(key_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    // three compare-and-subtract stages of the remainder by n
    function automatic logic [9:0] red3(input logic [9:0] x, input logic [8:0] n,
                                        input int hi);
        logic [17:0] r;
        logic [17:0] d;
        r = {8'd0, x};
        for (int k = 0; k < 3; k++)
        begin
            d = {9'd0, n} << (hi - k);
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return r[9:0];
    endfunction

    always_comb
    begin
        a_inc = (a_reg + 9'd1 >= n_val) ? 9'd0 : a_reg + 9'd1;
        b_inc = (b_reg + 9'd1 >= len_val) ? 9'd0 : b_reg + 9'd1;
    end

    always_comb
    begin
        ph_next = ph_reg; ret_next = ret_reg; a_next = a_reg; b_next = b_reg;
        j_next = j_reg; cnt_next = cnt_reg; si_next = si_reg; gi_next = gi_reg;
        gj_next = gj_reg; last_next = last_reg; rem_next = rem_reg;
        s_we = 1'b0; s_waddr = a_reg[AW-1:0]; s_wdata = si_reg;
        s_raddr = a_reg[AW-1:0]; k_raddr = b_reg[KW-1:0];
        status = '0;
        if (cmd.sched_done)
        begin
            gi_next = '0; gj_next = '0;
        end
        case (ph_reg)
            P_IDLE:
            begin
                if (cmd.init_start)
                begin
                    a_next = '0; ph_next = P_INIT;
                end
                else if (cmd.ksa_start)
                begin
                    a_next = '0; b_next = '0; j_next = '0;
                    cnt_next = rounds_val - 17'd1; ph_next = P_K0;
                end
                else if (cmd.gen_start)
                begin
                    a_next = {1'b0, gi_reg}; j_next = {1'b0, gj_reg};
                    cnt_next = {8'd0, steps_val} - 17'd1; ph_next = P_G0;
                end
            end
            P_INIT:
            begin
                s_we = 1'b1; s_wdata = a_reg[7:0];
                a_next = a_reg + 9'd1;
                if (a_reg + 9'd1 >= n_val)
                begin
                    ph_next = P_IDLE; status.init_done = 1'b1;
                end
            end
            P_K0: ph_next = P_K1;   // reads of S[a], K[b] in flight
            P_K1:
            begin
                si_next = s_rdata;
                rem_next = red3({1'b0, j_reg} + {2'd0, s_rdata} + {2'd0, k_rdata},
                                n_val, 8);
                ret_next = P_K2; ph_next = P_M1;
            end
            P_M1:
            begin
                rem_next = red3(rem_reg, n_val, 5); ph_next = P_M2;
            end
            P_M2:
            begin
                rem_next = red3(rem_reg, n_val, 2); ph_next = ret_reg;
            end
            P_K2:
            begin
                j_next = rem_reg[8:0]; s_raddr = rem_reg[AW-1:0]; ph_next = P_K3;
            end
            P_K3:
            begin
                s_we = 1'b1; s_waddr = a_reg[AW-1:0]; s_wdata = s_rdata;
                ph_next = P_K4;
            end
            P_K4:
            begin
                s_we = 1'b1; s_waddr = j_reg[AW-1:0]; s_wdata = si_reg;
                a_next = a_inc; b_next = b_inc;
                if (cnt_reg == '0)
                begin
                    ph_next = P_IDLE; status.ksa_done = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 17'd1; ph_next = P_K0;
                end
            end
            P_G0:
            begin
                rem_next = red3({1'b0, a_reg} + 10'd1, n_val, 8);
                ret_next = P_G1; ph_next = P_M1;
            end
            P_G1:
            begin
                a_next = rem_reg[8:0]; s_raddr = rem_reg[AW-1:0]; ph_next = P_G2;
            end
            P_G2:
            begin
                si_next = s_rdata;
                rem_next = red3({1'b0, j_reg} + {2'd0, s_rdata}, n_val, 8);
                ret_next = P_G3; ph_next = P_M1;
            end
            P_G3:
            begin
                j_next = rem_reg[8:0]; s_raddr = rem_reg[AW-1:0]; ph_next = P_G4;
            end
            P_G4:
            begin
                // s_rdata = S[j]; swap: S[i] <= S[j], S[j] <= si
                s_we = 1'b1; s_waddr = a_reg[AW-1:0]; s_wdata = s_rdata;
                si_next = s_rdata;  // new S[i]
                last_next = si_reg; // new S[j] held in last temporarily
                ph_next = P_G5;
            end
            P_G5:
            begin
                s_we = 1'b1; s_waddr = j_reg[AW-1:0]; s_wdata = last_reg;
                rem_next = red3({2'd0, si_reg} + {2'd0, last_reg}, n_val, 8);
                ret_next = P_G6; ph_next = P_M1;
            end
            P_G6:
            begin
                s_raddr = rem_reg[AW-1:0]; ph_next = P_G7;
            end
            P_G7:
            begin
                last_next = s_rdata;
                if (cnt_reg == '0)
                begin
                    gi_next = a_reg[7:0]; gj_next = j_reg[7:0];
                    status.gen_done = 1'b1; ph_next = P_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 17'd1; ph_next = P_G0;
                end
            end
            default: ph_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= P_IDLE; gi_reg <= '0; gj_reg <= '0;
        end
        else
        begin
            ph_reg <= ph_next; gi_reg <= gi_next; gj_reg <= gj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next; b_reg <= b_next; j_reg <= j_next; cnt_reg <= cnt_next;
        si_reg <= si_next; last_reg <= last_next; ret_reg <= ret_next;
        rem_reg <= rem_next;
    end

    assign last_byte = last_next;
endmodule

// File: design/rc4_ctrl.sv
// Controller of the RC4 block: item handshake, key bookkeeping, phase order.
// Depends on rc4_pkg and rc4_if.
`timescale 1ns / 1ps
module rc4_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    rc4_if.sink                  in_ch,
    rc4_if.source                out_ch,
    input  logic [7:0]           last_byte,
    input  rc4_pkg::dp_status_t  status,
    output rc4_pkg::dp_cmd_t     cmd,
    output logic                 key_we
);
    import rc4_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_INIT = 3'd1, S_KSA = 3'd2,
        S_GEN = 3'd3, S_OUT = 3'd4, S_KST = 3'd5;

    logic [2:0] st_reg, st_next;
    logic       scr_reg, scr_next, kp_reg, kp_next;
    logic       ov_reg, ov_next;
    out_item_t  od_reg, od_next;
    logic       acc;

    assign in_ch.ready = (st_reg == S_IDLE) && !ov_reg;
    assign acc = in_ch.valid && in_ch.ready;
    assign key_we = acc && (in_ch.data.kind == KIND_LOAD);
    assign out_ch.valid = ov_reg;
    assign out_ch.data = od_reg;

    always_comb
    begin
        st_next = st_reg; scr_next = scr_reg; kp_next = kp_reg;
        ov_next = ov_reg; od_next = od_reg; cmd = '0;
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (in_ch.data.kind == KIND_LOAD)
                    begin
                        kp_next = 1'b1; scr_next = 1'b0;
                    end
                    else if (!kp_reg)
                    begin
                        ov_next = 1'b1; od_next.keystream_byte = '0;
                        od_next.key_missing = 1'b1;
                    end
                    else if (!scr_reg)
                    begin
                        cmd.init_start = 1'b1; st_next = S_INIT;
                    end
                    else
                    begin
                        cmd.gen_start = 1'b1; st_next = S_GEN;
                    end
                end
            end
            S_INIT:
            begin
                if (status.init_done)
                begin
                    st_next = S_KST;
                end
            end
            S_KST:
            begin
                cmd.ksa_start = 1'b1; st_next = S_KSA;
            end
            S_KSA:
            begin
                if (status.ksa_done)
                begin
                    cmd.sched_done = 1'b1; scr_next = 1'b1; st_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.gen_start = 1'b1; st_next = S_GEN;
            end
            S_GEN:
            begin
                if (status.gen_done)
                begin
                    ov_next = 1'b1; od_next.keystream_byte = last_byte;
                    od_next.key_missing = 1'b0; st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; scr_reg <= 1'b0; kp_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; scr_reg <= scr_next; kp_reg <= kp_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end
endmodule

// File: design/rc4_checker.sv
// Port checker for the RC4 keystream block, bound to the top level.
// Depends on rc4_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rc4_variable_size_keystream_assert.svh"
module rc4_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input rc4_pkg::out_item_t out_data
);
    import rc4_pkg::*;
    `RC4_ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
    `RC4_ASSERT_IMPL(a_data_hold, clk, rst_n, out_valid && !out_ready |=> $stable(out_data))
    `RC4_ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid |-> !in_ready)
    `RC4_ASSERT_IMPL(a_missing_zero, clk, rst_n, out_valid && out_data.key_missing |-> out_data.keystream_byte == 8'd0)
    `RC4_ASSERT_RST(a_rst_idle, clk, rst_n, !rst_n |=> !out_valid)
endmodule

bind rc4_variable_size_keystream rc4_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
